@@ rtl/nsddb_pkg.sv @@
// Shared types and constants for the nested sphere depth-dose binner.
// No dependencies; imported by the controller, datapath and top level.
package nsddb_pkg;

    localparam int EVENT_W   = 32;
    localparam int POS_XZ_W  = 30;
    localparam int POS_Y_W   = 29;
    localparam int ENERGY_W  = 32;
    localparam int LEVEL_W   = 2;
    localparam int RD_BIN_W  = 8;
    localparam int SCORED_W  = 2;

    localparam logic CMD_SCORE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_LARGE  = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_SMALL  = 2'd2;

    typedef struct packed {
        logic               load;
        logic               decode;
        logic               rdout;
        logic               div_step;
        logic               rem_step;
        logic               dy_step;
        logic               sq_step;
        logic               bin_ovf;
        logic               wr;
        logic               out_load;
        logic               clr_en;
        logic [LEVEL_W-1:0] lev;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic ignore;
        logic near_ok;
        logic geom_ok;
        logic bin_ok;
    } stat_t;

endpackage

@@ rtl/nested_sphere_depth_dose_binner_top.sv @@
// Nested sphere depth-dose binner, top level: controller plus datapath.
// Read: decode, readout, done. Ignored hit: decode, done. Scored hit: decode, then per level
// tested divide, remainder, dy, square, compare and, if in range, write; then done. One item
// is processed at a time, the level sequencer sharing one divide/square unit; a waiting result
// does not block the next transfer in. Reset: synchronous, active low; then a clear sweep over
// max(bin counts) entries (256 at defaults) zeroes the histograms before any transfer is taken.
module nested_sphere_depth_dose_binner_top import nsddb_pkg::*; #(
    parameter int LARGE_BINS   = 64,
    parameter int MEDIUM_BINS  = 128,
    parameter int SMALL_BINS   = 256,
    parameter int LARGE_RADIUS = 5000000,
    parameter int SUM_WIDTH    = 48
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic [EVENT_W-1:0]         s_event_number,
    input  logic signed [POS_XZ_W-1:0] s_pos_x,
    input  logic [POS_Y_W-1:0]         s_pos_y,
    input  logic signed [POS_XZ_W-1:0] s_pos_z,
    input  logic [ENERGY_W-1:0]        s_energy,
    input  logic [LEVEL_W-1:0]         s_read_level,
    input  logic [RD_BIN_W-1:0]        s_read_bin,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [SCORED_W-1:0]        m_levels_scored,
    output logic                       m_hit_ignored,
    output logic                       m_bin_overflow,
    output logic [SUM_WIDTH-1:0]       m_bin_sum
);

    cmd_t  cmd;
    stat_t stat;

    nsddb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    nsddb_datapath #(
        .LARGE_BINS   (LARGE_BINS),
        .MEDIUM_BINS  (MEDIUM_BINS),
        .SMALL_BINS   (SMALL_BINS),
        .LARGE_RADIUS (LARGE_RADIUS),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_command       (s_command),
        .s_event_number  (s_event_number),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pos_z         (s_pos_z),
        .s_energy        (s_energy),
        .s_read_level    (s_read_level),
        .s_read_bin      (s_read_bin),
        .m_levels_scored (m_levels_scored),
        .m_hit_ignored   (m_hit_ignored),
        .m_bin_overflow  (m_bin_overflow),
        .m_bin_sum       (m_bin_sum)
    );

endmodule

@@ rtl/nsddb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nsddb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nsddb_datapath.sv @@
// Datapath: input capture, event tracking, bin division, sphere test,
// histogram RAMs with saturating accumulate, result registers. Uses nsddb_pkg, nsddb_ram.
module nsddb_datapath import nsddb_pkg::*; #(
    parameter int LARGE_BINS   = 64,
    parameter int MEDIUM_BINS  = 128,
    parameter int SMALL_BINS   = 256,
    parameter int LARGE_RADIUS = 5000000,
    parameter int SUM_WIDTH    = 48
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    input  logic                       s_command,
    input  logic [EVENT_W-1:0]         s_event_number,
    input  logic signed [POS_XZ_W-1:0] s_pos_x,
    input  logic [POS_Y_W-1:0]         s_pos_y,
    input  logic signed [POS_XZ_W-1:0] s_pos_z,
    input  logic [ENERGY_W-1:0]        s_energy,
    input  logic [LEVEL_W-1:0]         s_read_level,
    input  logic [RD_BIN_W-1:0]        s_read_bin,
    output logic [SCORED_W-1:0]        m_levels_scored,
    output logic                       m_hit_ignored,
    output logic                       m_bin_overflow,
    output logic [SUM_WIDTH-1:0]       m_bin_sum
);

    localparam longint unsigned R0 = LARGE_RADIUS;
    localparam longint unsigned R1 = (LARGE_RADIUS / 2 == 0) ? 1 : LARGE_RADIUS / 2;
    localparam longint unsigned R2 = (LARGE_RADIUS / 5 == 0) ? 1 : LARGE_RADIUS / 5;
    localparam longint unsigned D0 = 2 * R0;
    localparam longint unsigned D1 = 2 * R1;
    localparam longint unsigned D2 = 2 * R2;
    localparam int S0 = POS_Y_W + $clog2(D0);
    localparam int S1 = POS_Y_W + $clog2(D1);
    localparam int S2 = POS_Y_W + $clog2(D2);
    localparam longint unsigned M0 = ((64'd1 << S0) + D0 - 1) / D0;
    localparam longint unsigned M1 = ((64'd1 << S1) + D1 - 1) / D1;
    localparam longint unsigned M2 = ((64'd1 << S2) + D2 - 1) / D2;

    localparam int RW     = $clog2(R0 + 1);
    localparam int DW     = $clog2(D0 + 1);
    localparam int MW     = POS_Y_W + 1;
    localparam int PROD_W = POS_Y_W + MW;
    localparam int SHW    = $clog2(PROD_W);
    localparam int QD_W   = POS_Y_W + DW;
    localparam int BIN_W  = POS_Y_W + 1;
    localparam int SQW    = 2 * RW;
    localparam int TOT_W  = SQW + 2;

    localparam int AW0  = $clog2(LARGE_BINS);
    localparam int AW1  = $clog2(MEDIUM_BINS);
    localparam int AW2  = $clog2(SMALL_BINS);
    localparam int NMAX01 = (LARGE_BINS > MEDIUM_BINS) ? LARGE_BINS : MEDIUM_BINS;
    localparam int NMAX   = (NMAX01 > SMALL_BINS) ? NMAX01 : SMALL_BINS;
    localparam int CW     = $clog2(NMAX);

    // captured item
    logic                       cmd_reg;
    logic [EVENT_W-1:0]         evn_reg;
    logic [POS_XZ_W-1:0]        x_reg;
    logic [POS_Y_W-1:0]         y_reg;
    logic [POS_XZ_W-1:0]        z_reg;
    logic [ENERGY_W-1:0]        e_reg;
    logic [LEVEL_W-1:0]         lvl_reg;
    logic [RD_BIN_W-1:0]        rb_reg;

    // event state
    logic [POS_XZ_W-1:0]        prev_x_reg;
    logic [POS_Y_W-1:0]         prev_y_reg;
    logic [POS_XZ_W-1:0]        prev_z_reg;
    logic [EVENT_W-1:0]         cur_event_reg;
    logic                       closed_reg;

    // level pipeline
    logic [POS_XZ_W-1:0]        ax_reg;
    logic [POS_XZ_W-1:0]        az_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [POS_Y_W-1:0]         q_reg;
    logic [POS_Y_W-1:0]         qd_reg;
    logic [RW-1:0]              dy_reg;
    logic [BIN_W-1:0]           bin_reg;
    logic [SQW-1:0]             sqx_reg;
    logic [SQW-1:0]             sqy_reg;
    logic [SQW-1:0]             sqz_reg;
    logic [CW-1:0]              clr_cnt_reg;

    // working result and output
    logic [SCORED_W-1:0]        scored_reg;
    logic                       ignored_reg;
    logic                       ovf_reg;
    logic [SUM_WIDTH-1:0]       bsum_reg;
    logic [SCORED_W-1:0]        out_scored_reg;
    logic                       out_ignored_reg;
    logic                       out_ovf_reg;
    logic [SUM_WIDTH-1:0]       out_bsum_reg;

    logic [RW-1:0]              r_sel;
    logic [DW-1:0]              d_sel;
    logic [MW-1:0]              m_sel;
    logic [SHW-1:0]             s_sel;
    logic [TOT_W-1:0]           rr_sel;
    logic [31:0]                n_sel;
    logic [31:0]                n_rd;
    logic [SUM_WIDTH-1:0]       cur_sel;
    logic [SUM_WIDTH-1:0]       rd_sel;

    logic                       same_pos;
    logic                       closed_eff;
    logic                       ignore;
    logic [POS_XZ_W-1:0]        ax_next;
    logic [POS_XZ_W-1:0]        az_next;
    logic [PROD_W-1:0]          q_full;
    logic [POS_Y_W-1:0]         q_cur;
    logic [QD_W-1:0]            qd_full;
    logic [POS_Y_W-1:0]         rem;
    logic [31:0]                rem32;
    logic [31:0]                r32;
    logic [RW-1:0]              dy_next;
    logic [BIN_W-1:0]           bin_next;
    logic [RW-1:0]              axr;
    logic [RW-1:0]              azr;
    logic [TOT_W-1:0]           tot;
    logic [SUM_WIDTH:0]         acc;
    logic                       sat;
    logic [SUM_WIDTH-1:0]       wsum;
    logic                       rd_ok;
    logic [31:0]                rb32;

    logic [SUM_WIDTH-1:0]       rd0;
    logic [SUM_WIDTH-1:0]       rd1;
    logic [SUM_WIDTH-1:0]       rd2;
    logic                       we0;
    logic                       we1;
    logic                       we2;
    logic [SUM_WIDTH-1:0]       wdata;

    always_comb begin
        case (cmd.lev)
            LVL_MEDIUM: begin
                r_sel  = RW'(R1);
                d_sel  = DW'(D1);
                m_sel  = MW'(M1);
                s_sel  = SHW'(S1);
                rr_sel = TOT_W'(R1 * R1);
                n_sel  = 32'(MEDIUM_BINS);
                cur_sel = rd1;
            end
            LVL_SMALL: begin
                r_sel  = RW'(R2);
                d_sel  = DW'(D2);
                m_sel  = MW'(M2);
                s_sel  = SHW'(S2);
                rr_sel = TOT_W'(R2 * R2);
                n_sel  = 32'(SMALL_BINS);
                cur_sel = rd2;
            end
            default: begin
                r_sel  = RW'(R0);
                d_sel  = DW'(D0);
                m_sel  = MW'(M0);
                s_sel  = SHW'(S0);
                rr_sel = TOT_W'(R0 * R0);
                n_sel  = 32'(LARGE_BINS);
                cur_sel = rd0;
            end
        endcase
    end

    always_comb begin
        case (lvl_reg)
            LVL_LARGE: begin
                n_rd   = 32'(LARGE_BINS);
                rd_sel = rd0;
            end
            LVL_MEDIUM: begin
                n_rd   = 32'(MEDIUM_BINS);
                rd_sel = rd1;
            end
            LVL_SMALL: begin
                n_rd   = 32'(SMALL_BINS);
                rd_sel = rd2;
            end
            default: begin
                n_rd   = 32'd0;
                rd_sel = '0;
            end
        endcase
    end

    assign rb32  = 32'(rb_reg);
    assign rd_ok = (rb32 < n_rd);

    // event bookkeeping
    assign same_pos   = (x_reg == prev_x_reg) && (y_reg == prev_y_reg) && (z_reg == prev_z_reg);
    assign closed_eff = (evn_reg != cur_event_reg) ? 1'b0 : closed_reg;
    assign ignore     = closed_eff || same_pos;
    assign ax_next    = x_reg[POS_XZ_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign az_next    = z_reg[POS_XZ_W-1] ? (~z_reg + 1'b1) : z_reg;

    // bin = ceil(y / d) via reciprocal multiply
    assign q_full  = prod_reg >> s_sel;
    assign q_cur   = q_full[POS_Y_W-1:0];
    assign qd_full = QD_W'(q_cur) * QD_W'(d_sel);
    assign rem     = y_reg - qd_reg;
    assign rem32   = 32'(rem);
    assign r32     = 32'(r_sel);
    assign dy_next = (rem == '0) ? '0 :
                     (rem32 >= r32) ? RW'(rem32 - r32) : RW'(r32 - rem32);
    assign bin_next = (rem == '0) ? BIN_W'(q_reg) : BIN_W'(q_reg) + 1'b1;

    assign axr = RW'(ax_reg);
    assign azr = RW'(az_reg);
    assign tot = TOT_W'(sqx_reg) + TOT_W'(sqy_reg) + TOT_W'(sqz_reg);

    // saturating accumulate
    assign acc  = {1'b0, cur_sel} + (SUM_WIDTH + 1)'(e_reg);
    assign sat  = acc[SUM_WIDTH];
    assign wsum = sat ? '1 : acc[SUM_WIDTH-1:0];

    assign stat.clr_last = (clr_cnt_reg == CW'(NMAX - 1));
    assign stat.is_read  = (cmd_reg == CMD_READ);
    assign stat.ignore   = ignore;
    assign stat.near_ok  = (32'(ax_reg) < r32) && (32'(az_reg) < r32) && (e_reg != '0);
    assign stat.geom_ok  = (tot <= rr_sel);
    assign stat.bin_ok   = (32'(bin_reg) < n_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            cur_event_reg <= '0;
            closed_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
        end else begin
            if (cmd.clr_en) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.decode && cmd_reg == CMD_SCORE) begin
                cur_event_reg <= evn_reg;
                closed_reg    <= ignore;
                if (!ignore) begin
                    prev_x_reg <= x_reg;
                    prev_y_reg <= y_reg;
                    prev_z_reg <= z_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg     <= s_command;
            evn_reg     <= s_event_number;
            x_reg       <= s_pos_x;
            y_reg       <= s_pos_y;
            z_reg       <= s_pos_z;
            e_reg       <= s_energy;
            lvl_reg     <= s_read_level;
            rb_reg      <= s_read_bin;
            scored_reg  <= '0;
            ignored_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            bsum_reg    <= '0;
        end
        if (cmd.decode) begin
            ax_reg <= ax_next;
            az_reg <= az_next;
            if (cmd_reg == CMD_SCORE) begin
                ignored_reg <= ignore;
            end
        end
        if (cmd.rdout) begin
            if (rd_ok) begin
                bsum_reg <= rd_sel;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.div_step) begin
            prod_reg <= PROD_W'(y_reg) * PROD_W'(m_sel);
        end
        if (cmd.rem_step) begin
            q_reg  <= q_cur;
            qd_reg <= qd_full[POS_Y_W-1:0];
        end
        if (cmd.dy_step) begin
            dy_reg  <= dy_next;
            bin_reg <= bin_next;
        end
        if (cmd.sq_step) begin
            sqx_reg <= SQW'(axr) * SQW'(axr);
            sqy_reg <= SQW'(dy_reg) * SQW'(dy_reg);
            sqz_reg <= SQW'(azr) * SQW'(azr);
        end
        if (cmd.bin_ovf) begin
            ovf_reg <= 1'b1;
        end
        if (cmd.wr) begin
            scored_reg <= scored_reg + 1'b1;
            if (sat) begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_scored_reg  <= scored_reg;
            out_ignored_reg <= ignored_reg;
            out_ovf_reg     <= ovf_reg;
            out_bsum_reg    <= bsum_reg;
        end
    end

    assign m_levels_scored = out_scored_reg;
    assign m_hit_ignored   = out_ignored_reg;
    assign m_bin_overflow  = out_ovf_reg;
    assign m_bin_sum       = out_bsum_reg;

    // histogram stores
    assign wdata = cmd.clr_en ? '0 : wsum;
    assign we0 = (cmd.clr_en && 32'(clr_cnt_reg) < 32'(LARGE_BINS)) ||
                 (cmd.wr && cmd.lev == LVL_LARGE);
    assign we1 = (cmd.clr_en && 32'(clr_cnt_reg) < 32'(MEDIUM_BINS)) ||
                 (cmd.wr && cmd.lev == LVL_MEDIUM);
    assign we2 = (cmd.clr_en && 32'(clr_cnt_reg) < 32'(SMALL_BINS)) ||
                 (cmd.wr && cmd.lev == LVL_SMALL);

    nsddb_ram #(.WIDTH(SUM_WIDTH), .DEPTH(LARGE_BINS)) u_large_ram (
        .aclk  (aclk),
        .we    (we0),
        .waddr (cmd.clr_en ? clr_cnt_reg[AW0-1:0] : bin_reg[AW0-1:0]),
        .wdata (wdata),
        .raddr (stat.is_read ? rb32[AW0-1:0] : bin_reg[AW0-1:0]),
        .rdata (rd0)
    );

    nsddb_ram #(.WIDTH(SUM_WIDTH), .DEPTH(MEDIUM_BINS)) u_medium_ram (
        .aclk  (aclk),
        .we    (we1),
        .waddr (cmd.clr_en ? clr_cnt_reg[AW1-1:0] : bin_reg[AW1-1:0]),
        .wdata (wdata),
        .raddr (stat.is_read ? rb32[AW1-1:0] : bin_reg[AW1-1:0]),
        .rdata (rd1)
    );

    nsddb_ram #(.WIDTH(SUM_WIDTH), .DEPTH(SMALL_BINS)) u_small_ram (
        .aclk  (aclk),
        .we    (we2),
        .waddr (cmd.clr_en ? clr_cnt_reg[AW2-1:0] : bin_reg[AW2-1:0]),
        .wdata (wdata),
        .raddr (stat.is_read ? rb32[AW2-1:0] : bin_reg[AW2-1:0]),
        .rdata (rd2)
    );

endmodule

@@ rtl/nsddb_ctrl.sv @@
// Controller: clear sweep, item sequencing over the three sphere levels,
// and the result channel valid. Uses nsddb_pkg.
module nsddb_ctrl import nsddb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RDOUT,
        ST_DIV,
        ST_REM,
        ST_DY,
        ST_SQ,
        ST_CMP,
        ST_WR,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [LEVEL_W-1:0] lev_reg;
    logic               m_valid_reg;
    logic               last_lev;
    logic               out_free;

    assign last_lev = (lev_reg == LVL_SMALL);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.lev      = lev_reg;
        cmd.load     = s_ready && s_valid;
        cmd.clr_en   = (state_reg == ST_CLEAR);
        cmd.decode   = (state_reg == ST_DECODE);
        cmd.rdout    = (state_reg == ST_RDOUT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.rem_step = (state_reg == ST_REM);
        cmd.dy_step  = (state_reg == ST_DY);
        cmd.sq_step  = (state_reg == ST_SQ);
        cmd.bin_ovf  = (state_reg == ST_CMP) && stat.geom_ok && !stat.bin_ok;
        cmd.wr       = (state_reg == ST_WR);
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            lev_reg     <= LVL_LARGE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (stat.clr_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    lev_reg <= LVL_LARGE;
                    if (stat.is_read) begin
                        state_reg <= ST_RDOUT;
                    end else if (stat.ignore) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_RDOUT: begin
                    state_reg <= ST_DONE;
                end
                ST_DIV: begin
                    state_reg <= stat.near_ok ? ST_REM : ST_DONE;
                end
                ST_REM: begin
                    state_reg <= ST_DY;
                end
                ST_DY: begin
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (!stat.geom_ok) begin
                        state_reg <= ST_DONE;
                    end else if (stat.bin_ok) begin
                        state_reg <= ST_WR;
                    end else if (last_lev) begin
                        state_reg <= ST_DONE;
                    end else begin
                        lev_reg   <= lev_reg + 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_WR: begin
                    if (last_lev) begin
                        state_reg <= ST_DONE;
                    end else begin
                        lev_reg   <= lev_reg + 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
